/* design/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSPC_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSPC_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rspc_pkg.sv */
`timescale 1ns / 1ps
package rspc_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_INIT  = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_TOO_SMALL = 3'd5,
    ST_MISSING   = 3'd6,
    ST_INTERNAL  = 3'd7
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_PREP,
    S_GAP,
    S_APPEND,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_LK_RD,
    S_LK_CHK,
    S_FL_RD,
    S_FL_CHK,
    S_DONE
  } state_e;

  // Request kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Shortest acceptable packet in bytes (fixed RTP header).
  localparam logic [15:0] MIN_PKT_LEN = 16'd12;

  // One slot of the packet window.
  typedef struct packed {
    logic        vld;
    logic [15:0] seq;
    logic [31:0] hdl;
    logic [15:0] len;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    calc;
    logic    lock;
    logic    restart;
    logic    prep;
    logic    gap_wr;
    logic    app_wr;
    logic    rd_idx;
    logic    rd_head;
    logic    fill_wr;
    logic    drop;
    logic    load_out;
    logic    hit;
    status_e status;
  } ctl_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic kind;
    logic ninit;
    logic lk_ninit;
    logic short_pkt;
    logic src_bad;
    logic empty;
    logic jump;
    logic ahead;
    logic far;
    logic in_span;
    logic in_cnt;
    logic too_large;
    logic too_small;
    logic gap_done;
    logic rd_vld;
    logic rd_match;
  } dp_sts_t;

endpackage

/* design/rspc_req_if.sv */
`timescale 1ns / 1ps
interface rspc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] seq_num;
  logic [31:0] src_id;
  logic [31:0] media_time;
  logic [15:0] pkt_len;
  logic [31:0] pkt_handle;

  modport source (output valid, kind, seq_num, src_id, media_time, pkt_len, pkt_handle,
                  input ready);
  modport sink (input valid, kind, seq_num, src_id, media_time, pkt_len, pkt_handle,
                output ready);
endinterface

/* design/rspc_rsp_if.sv */
`timescale 1ns / 1ps
interface rspc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_handle;
  logic [15:0] found_len;

  modport source (output valid, status, found_handle, found_len, input ready);
  modport sink (input valid, status, found_handle, found_len, output ready);
endinterface

/* design/rspc_ctrl.sv */
`timescale 1ns / 1ps
module rspc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  rspc_pkg::dp_sts_t  sts_i,
  output rspc_pkg::ctl_cmd_t cmd_o
);
  import rspc_pkg::*;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    hit_q, hit_d;
  logic    ovld_q, ovld_d;
  logic    out_free;

  assign out_free    = !ovld_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = ovld_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_CALC;
      end
      S_CALC: state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_DONE;
        if (sts_i.kind == KIND_LOOKUP) begin
          if (!sts_i.lk_ninit && !sts_i.empty && !sts_i.too_large && !sts_i.too_small &&
              sts_i.in_cnt) begin
            state_d = S_LK_RD;
          end
        end else if (!sts_i.ninit && !sts_i.short_pkt && !sts_i.src_bad &&
                     !sts_i.empty && !sts_i.jump) begin
          if (sts_i.ahead) state_d = S_PREP;
          else if (!sts_i.far && sts_i.in_span && sts_i.in_cnt) state_d = S_FL_RD;
        end
      end
      S_PREP:     state_d = S_GAP;
      S_GAP: begin
        if (sts_i.gap_done) state_d = S_APPEND;
      end
      S_APPEND:   state_d = S_TRIM_RD;
      S_TRIM_RD:  state_d = S_TRIM_CHK;
      S_TRIM_CHK: state_d = sts_i.rd_vld ? S_DONE : S_TRIM_RD;
      S_LK_RD:    state_d = S_LK_CHK;
      S_LK_CHK:   state_d = S_DONE;
      S_FL_RD:    state_d = S_FL_CHK;
      S_FL_CHK:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands and result bookkeeping.
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = st_q;
    cmd_o.hit    = hit_q;
    st_d         = st_q;
    hit_d        = hit_q;
    ovld_d       = ovld_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch = req_valid_i;
        hit_d       = 1'b0;
      end
      S_CALC: cmd_o.calc = 1'b1;
      S_DECIDE: begin
        if (sts_i.kind == KIND_LOOKUP) begin
          if (sts_i.lk_ninit)       st_d = ST_NOT_INIT;
          else if (sts_i.empty)     st_d = ST_EMPTY;
          else if (sts_i.too_large) st_d = ST_TOO_LARGE;
          else if (sts_i.too_small) st_d = ST_TOO_SMALL;
          else if (!sts_i.in_cnt)   st_d = ST_MISSING;
          else                      st_d = ST_OK;
        end else begin
          cmd_o.lock = !sts_i.ninit && !sts_i.short_pkt;
          if (sts_i.ninit)                          st_d = ST_NOT_INIT;
          else if (sts_i.short_pkt || sts_i.src_bad) st_d = ST_INVALID;
          else if (sts_i.empty || sts_i.jump) begin
            cmd_o.restart = 1'b1;
            st_d          = ST_OK;
          end else if (sts_i.ahead)                 st_d = ST_OK;
          else if (sts_i.far) begin
            cmd_o.restart = 1'b1;
            st_d          = ST_OK;
          end else if (sts_i.in_span)               st_d = ST_OK;
          else                                      st_d = ST_INTERNAL;
        end
      end
      S_PREP:    cmd_o.prep = 1'b1;
      S_GAP:     cmd_o.gap_wr = !sts_i.gap_done;
      S_APPEND:  cmd_o.app_wr = 1'b1;
      S_TRIM_RD: cmd_o.rd_head = 1'b1;
      S_TRIM_CHK: cmd_o.drop = !sts_i.rd_vld;
      S_LK_RD:   cmd_o.rd_idx = 1'b1;
      S_LK_CHK: begin
        if (!sts_i.rd_vld)        st_d = ST_MISSING;
        else if (!sts_i.rd_match) st_d = ST_INTERNAL;
        else begin
          st_d  = ST_OK;
          hit_d = 1'b1;
        end
      end
      S_FL_RD:   cmd_o.rd_idx = 1'b1;
      S_FL_CHK:  cmd_o.fill_wr = !sts_i.rd_vld;
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          ovld_d         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      hit_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      hit_q   <= hit_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

/* design/rspc_dp.sv */
`timescale 1ns / 1ps
module rspc_dp #(
  parameter int DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [17:0]        media_rate_i,
  input  logic [12:0]        window_size_i,
  input  logic               kind_i,
  input  logic [15:0]        seq_num_i,
  input  logic [31:0]        src_id_i,
  input  logic [31:0]        media_time_i,
  input  logic [15:0]        pkt_len_i,
  input  logic [31:0]        pkt_handle_i,
  input  rspc_pkg::ctl_cmd_t cmd_i,
  output rspc_pkg::dp_sts_t  sts_o,
  output logic [2:0]         status_o,
  output logic [31:0]        found_handle_o,
  output logic [15:0]        found_len_o
);
  import rspc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Ring position plus offset, wrapped once at the depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CW + 1)'(DEPTH)) sum = sum - (CW + 1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  // Latched request.
  logic        kind_q;
  logic [15:0] seq_q, len_q;
  logic [31:0] src_q, time_q, hdl_q;

  // Window state.
  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [15:0]   front_q, back_q, gap_q;
  logic [31:0]   btime_q, lock_q;

  // Decision flags and offsets captured in the calculation cycle.
  dp_sts_t     f_q, f_d;
  logic [15:0] dback_q, dfront_q;

  // Slot memory.
  slot_t         mem [DEPTH];
  slot_t         rd_q, wdata;
  logic          we;
  logic [AW-1:0] waddr, raddr, idx;

  // Effective window size, clipped to the depth.
  logic [16:0] wv;
  assign wv = (17'(window_size_i) < 17'(DEPTH)) ? 17'(window_size_i) : 17'(DEPTH);

  // Classification of the latched request.
  logic [31:0] diff, mag;
  logic [22:0] thr;
  logic [15:0] dback, dfront, dfs, expect_seq, a_off, b_off;
  always_comb begin
    diff       = btime_q - time_q;
    mag        = diff[31] ? (32'd0 - diff) : diff;
    thr        = {1'b0, media_rate_i, 4'b0} + {3'b0, media_rate_i, 2'b0};
    dback      = seq_q - back_q;
    dfront     = seq_q - front_q;
    dfs        = front_q - seq_q;
    expect_seq = back_q + wv[15:0];
    a_off      = seq_q - expect_seq;
    b_off      = front_q - expect_seq;
    f_d           = '0;
    f_d.kind      = kind_q;
    f_d.ninit     = (media_rate_i == 18'd0);
    f_d.lk_ninit  = (media_rate_i == 18'd0) || (window_size_i == 13'd0);
    f_d.short_pkt = (len_q < MIN_PKT_LEN);
    f_d.src_bad   = (lock_q != 32'd0) && (src_q != lock_q);
    f_d.empty     = (count_q == '0);
    f_d.jump      = (mag >= 32'(thr));
    f_d.ahead     = (dback != 16'd0) && (17'(dback) < wv);
    f_d.far       = (a_off < b_off);
    f_d.in_span   = (dfront <= (back_q - front_q));
    f_d.in_cnt    = (17'(dfront) < 17'(count_q));
    f_d.too_large = (dback != 16'd0) && !dback[15];
    f_d.too_small = (dfs != 16'd0) && !dfs[15];
  end

  // Front trimming to the window size before a gap fill.
  logic [17:0]   need;
  logic [17:0]   excess;
  logic [CW-1:0] drops;
  always_comb begin
    need   = 18'(count_q) + 18'(dback_q);
    excess = (need > 18'(wv)) ? (need - 18'(wv)) : 18'd0;
    drops  = (excess > 18'(count_q)) ? count_q : excess[CW-1:0];
  end

  // Status back to the controller.
  always_comb begin
    sts_o          = f_q;
    sts_o.gap_done = (gap_q == 16'd0);
    sts_o.rd_vld   = rd_q.vld;
    sts_o.rd_match = (rd_q.seq == seq_q);
  end

  // Memory addressing.
  assign idx   = ring_add(head_q, dfront_q[CW-1:0]);
  assign raddr = cmd_i.rd_head ? head_q : idx;
  always_comb begin
    we    = cmd_i.restart || cmd_i.gap_wr || cmd_i.app_wr || cmd_i.fill_wr;
    waddr = ring_add(head_q, count_q);
    wdata = '{vld: 1'b1, seq: seq_q, hdl: hdl_q, len: len_q};
    if (cmd_i.restart) waddr = '0;
    else if (cmd_i.fill_wr) waddr = idx;
    else if (cmd_i.gap_wr) wdata = '0;
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_head || cmd_i.rd_idx) rd_q <= mem[raddr];
  end

  // Request latch and captured flags.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      seq_q  <= seq_num_i;
      src_q  <= src_id_i;
      time_q <= media_time_i;
      len_q  <= pkt_len_i;
      hdl_q  <= pkt_handle_i;
    end
    if (cmd_i.calc) begin
      f_q      <= f_d;
      dback_q  <= dback;
      dfront_q <= dfront;
    end
  end

  // Window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      front_q <= '0;
      back_q  <= '0;
      btime_q <= '0;
      lock_q  <= '0;
      gap_q   <= '0;
    end else begin
      if (cmd_i.lock && (lock_q == 32'd0)) lock_q <= src_q;
      if (cmd_i.restart) begin
        head_q  <= '0;
        count_q <= CW'(1);
        front_q <= seq_q;
        back_q  <= seq_q;
        btime_q <= time_q;
      end
      if (cmd_i.prep) begin
        head_q  <= ring_add(head_q, drops);
        count_q <= count_q - drops;
        front_q <= front_q + 16'(drops);
        gap_q   <= dback_q - 16'd1;
      end
      if (cmd_i.gap_wr) begin
        count_q <= count_q + CW'(1);
        back_q  <= back_q + 16'd1;
        gap_q   <= gap_q - 16'd1;
      end
      if (cmd_i.app_wr) begin
        count_q <= count_q + CW'(1);
        back_q  <= seq_q;
        btime_q <= time_q;
      end
      if (cmd_i.drop) begin
        head_q  <= ring_add(head_q, CW'(1));
        count_q <= count_q - CW'(1);
        front_q <= front_q + 16'd1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o       <= cmd_i.status;
      found_handle_o <= cmd_i.hit ? rd_q.hdl : 32'd0;
      found_len_o    <= cmd_i.hit ? rd_q.len : 16'd0;
    end
  end

endmodule

/* design/rtp_seq_packet_cache.sv */
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_i     in         kind, seq_num, src_id, media_time, pkt_len, pkt_handle
// rsp_o     out        status, found_handle, found_len
// apb       in/out     media clock rate at 0x0, window size at 0x4
//
// A rejected or restarting insert, or a lookup refused on its indices, goes through the
// calculation and decision states to its result; a lookup or an insert that reads a slot
// inside the window first reads that slot and checks it. An insert ahead of the back trims
// the front, writes an empty slot per gap number, appends, then drops empty front slots.
// One request is in work at a time and the next is taken the cycle after its result is
// loaded, which waits while the previous result is stalled. Reset empties the window.
module rtp_seq_packet_cache #(
  parameter int DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rspc_req_if.sink    req_i,
  rspc_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rspc_pkg::*;

  logic [17:0] media_rate_q;
  logic [12:0] window_size_q;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;
  logic        req_ready;

  // Configuration registers.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {19'd0, window_size_q} : {14'd0, media_rate_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      media_rate_q  <= '0;
      window_size_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) window_size_q <= pwdata[12:0];
      else          media_rate_q  <= pwdata[17:0];
    end
  end

  assign req_i.ready = req_ready;

  rspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rspc_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .media_rate_i   (media_rate_q),
    .window_size_i  (window_size_q),
    .kind_i         (req_i.kind),
    .seq_num_i      (req_i.seq_num),
    .src_id_i       (req_i.src_id),
    .media_time_i   (req_i.media_time),
    .pkt_len_i      (req_i.pkt_len),
    .pkt_handle_i   (req_i.pkt_handle),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (rsp_o.status),
    .found_handle_o (rsp_o.found_handle),
    .found_len_o    (rsp_o.found_len)
  );

endmodule

/* design/rspc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rspc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_handle_i,
  input logic [15:0] rsp_len_i
);
  import rspc_pkg::*;

  logic accepted, rsp_stall, rsp_fail, rsp_zero;

  // Handshake and payload conditions.
  assign accepted  = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_fail  = rsp_valid_i && (rsp_status_i != ST_OK);
  assign rsp_zero  = (rsp_handle_i == 32'd0) && (rsp_len_i == 16'd0);

  // Only one request is in work: ready drops after each acceptance.
  `RSPC_NXT(a_one_request, clk_i, rst_ni, accepted, !req_ready_i, "ready after accept")

  // A stalled result stays valid and keeps its status.
  `RSPC_NXT(a_rsp_keep, clk_i, rst_ni, rsp_stall, rsp_valid_i, "result dropped under stall")
  `RSPC_NXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, $stable(rsp_status_i), "status changed")

  // Only a successful result carries a handle or a length.
  `RSPC_IMP(a_fail_zero, clk_i, rst_ni, rsp_fail, rsp_zero, "payload on failed result")

endmodule

bind rtp_seq_packet_cache rspc_checker u_rspc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_handle_i (rsp_o.found_handle),
  .rsp_len_i    (rsp_o.found_len)
);
